// File: rtl/ilf_pkg.sv
// Shared widths, codes and types of the incremental line fit block.
`timescale 1ns / 1ps

package ilf_pkg;

  localparam int SMP_W           = 24;
  localparam int CNT_W           = 11;
  localparam int SUM1_W          = 34;
  localparam int SUM2_W          = 58;
  localparam int LIM_W           = 40;
  localparam int WIDE_W          = 104;
  localparam int Q_W             = 32;
  localparam int STAT_W          = 3;
  localparam int OP_W            = 2;
  localparam int STEP_W          = 6;
  localparam int IN_W            = 56;
  localparam int OUT_W           = 80;
  localparam int SNUM_SH         = 16;
  localparam int MAX_SAMPLES_DEF = 1024;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic signed [SUM1_W-1:0] sum1_t;
  typedef logic signed [SUM2_W-1:0] sum2_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic        [LIM_W-1:0]  lim_t;
  typedef logic        [SUM1_W-1:0] mplr_t;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

  localparam logic [STAT_W-1:0] ST_ACCEPT   = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL_FIT = 3'd2;
  localparam logic [STAT_W-1:0] ST_OFFSET   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(SUM1_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(Q_W - 1);

  typedef struct packed {
    logic  wr_xx;
    logic  commit;
    logic  remove;
    smp_t  x;
    smp_t  y;
  } sum_upd_t;

  typedef struct packed {
    cnt_t  cnt;
    sum1_t sx;
    sum2_t sxx;
    sum1_t sy;
    sum2_t sxy;
    logic  full;
    logic  empty;
  } sum_state_t;

endpackage

// File: rtl/incremental_line_fit.sv
// Incremental least-squares line fit: sequencer, shift-add multiply and divide.
// One word at a time. Add/remove: two 34-step shift-add multiplies. Evaluate: six
// multiplies and two 32-step divides for a full fit, two multiplies and one divide
// for offset only, no divide if empty, none if rejected; all on one 104-bit adder.
// The output register lets a new word enter while the last result waits.
// Reset clears the count, all sums and the limit register at once.
`timescale 1ns / 1ps

module incremental_line_fit #(
  parameter int MAX_SAMPLES = ilf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // op[1:0], sample_x[25:2], sample_y[49:26], zero pad
  input  logic [ilf_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[2:0], fit_slope[34:3], fit_offset[66:35], sample_count[77:67], zero pad
  output logic [ilf_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [ilf_pkg::LIM_W-1:0]  cfg_wdata_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_POST  = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_DABS  = 4'd6;
  localparam logic [3:0] S_DRND  = 4'd7;
  localparam logic [3:0] S_DCHK  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DEND  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // multiply jobs
  localparam logic [2:0] M_XX     = 3'd0;
  localparam logic [2:0] M_XY     = 3'd1;
  localparam logic [2:0] M_DET_A  = 3'd2;
  localparam logic [2:0] M_DET_B  = 3'd3;
  localparam logic [2:0] M_ONUM_A = 3'd4;
  localparam logic [2:0] M_ONUM_B = 3'd5;
  localparam logic [2:0] M_SNUM_A = 3'd6;
  localparam logic [2:0] M_SNUM_B = 3'd7;

  // divide jobs
  localparam logic [1:0] J_OFF_FIT  = 2'd0;
  localparam logic [1:0] J_SLOPE    = 2'd1;
  localparam logic [1:0] J_OFF_MEAN = 2'd2;

  localparam logic [ilf_pkg::Q_W-1:0] POS_MAX = {1'b0, {(ilf_pkg::Q_W-1){1'b1}}};
  localparam logic [ilf_pkg::Q_W-1:0] NEG_MIN = {1'b1, {(ilf_pkg::Q_W-1){1'b0}}};

  logic [3:0]                  state_q, state_d;
  logic [ilf_pkg::OP_W-1:0]    op_q, op_d;
  ilf_pkg::smp_t               x_q, x_d, y_q, y_d;
  logic [2:0]                  mi_q, mi_d;
  logic [ilf_pkg::STEP_W-1:0]  step_q, step_d;
  ilf_pkg::wide_t              acc_q, acc_d, mcand_q, mcand_d;
  ilf_pkg::mplr_t              mplier_q, mplier_d;
  ilf_pkg::wide_t              det_q, det_d, num_q, num_d, r_q, r_d;
  logic [ilf_pkg::Q_W-1:0]     q_q, q_d;
  logic                        sat_q, sat_d, dneg_q, dneg_d, den_neg_q, den_neg_d;
  logic [1:0]                  job_q, job_d;
  logic [ilf_pkg::STAT_W-1:0]  status_q, status_d;
  logic [ilf_pkg::Q_W-1:0]     slope_q, slope_d, offset_q, offset_d;
  logic                        m_valid_q, m_valid_d;
  logic [ilf_pkg::OUT_W-1:0]   m_data_q, m_data_d;

  ilf_pkg::sum_upd_t           upd;
  ilf_pkg::sum_state_t         sums;
  ilf_pkg::lim_t               lim;

  ilf_pkg::wide_t              alu_a, alu_b, alu_sum;
  logic                        alu_sub, alu_carry;
  logic                        mneg;
  logic                        in_rej;
  logic [ilf_pkg::OP_W-1:0]    in_op;
  logic [ilf_pkg::Q_W-1:0]     div_res;

  assign in_op = s_axis_tdata[1:0];

  ilf_sums #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_sums (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .wr_data_i   (acc_q[ilf_pkg::SUM2_W-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .st_o        (sums),
    .lim_o       (lim)
  );

  ilf_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  always_comb begin
    unique case (in_op)
      ilf_pkg::OP_ADD:    in_rej = sums.full;
      ilf_pkg::OP_REMOVE: in_rej = sums.empty;
      ilf_pkg::OP_EVAL:   in_rej = 1'b0;
      default:            in_rej = 1'b1;
    endcase
  end

  // second pair terms and removes subtract; the multiplier sign bit inverts
  always_comb begin
    unique case (mi_q) inside
      M_XX, M_XY:                   mneg = (op_q == ilf_pkg::OP_REMOVE);
      M_DET_B, M_ONUM_B, M_SNUM_B:  mneg = 1'b1;
      default:                      mneg = 1'b0;
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q) inside
      S_MUL: begin
        alu_a   = acc_q;
        alu_b   = mplier_q[0] ? mcand_q : '0;
        alu_sub = mneg ^ (step_q == ilf_pkg::MUL_LAST);
      end
      S_ABS: begin
        alu_b   = det_q;
        alu_sub = 1'b1;
      end
      S_CMP: begin
        alu_a   = ilf_pkg::wide_t'(lim);
        alu_b   = det_q;
        alu_sub = 1'b1;
      end
      S_DABS: begin
        alu_b   = num_q;
        alu_sub = 1'b1;
      end
      S_DRND: begin
        alu_a   = {r_q[ilf_pkg::WIDE_W-2:0], 1'b0};
        alu_b   = det_q;
      end
      S_DCHK, S_DIV: begin
        alu_a   = r_q;
        alu_b   = mcand_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (sat_q) begin
      div_res = dneg_q ? NEG_MIN : POS_MAX;
    end else if (!dneg_q) begin
      div_res = (q_q > POS_MAX) ? POS_MAX : q_q;
    end else begin
      div_res = (q_q > NEG_MIN) ? NEG_MIN : (~q_q + ilf_pkg::Q_W'(1));
    end
  end

  always_comb begin
    logic       start_mul;
    logic [2:0] start_idx;
    start_mul  = 1'b0;
    start_idx  = mi_q;
    state_d    = state_q;
    op_d       = op_q;
    x_d        = x_q;
    y_d        = y_q;
    mi_d       = mi_q;
    step_d     = step_q;
    acc_d      = acc_q;
    mcand_d    = mcand_q;
    mplier_d   = mplier_q;
    det_d      = det_q;
    num_d      = num_q;
    r_d        = r_q;
    q_d        = q_q;
    sat_d      = sat_q;
    dneg_d     = dneg_q;
    den_neg_d  = den_neg_q;
    job_d      = job_q;
    status_d   = status_q;
    slope_d    = slope_q;
    offset_d   = offset_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    upd.wr_xx  = 1'b0;
    upd.commit = 1'b0;
    upd.remove = (op_q == ilf_pkg::OP_REMOVE);
    upd.x      = x_q;
    upd.y      = y_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = in_op;
          x_d      = s_axis_tdata[25:2];
          y_d      = s_axis_tdata[49:26];
          slope_d  = '0;
          offset_d = '0;
          if (in_rej) begin
            status_d = ilf_pkg::ST_REJECT;
            state_d  = S_DONE;
          end else begin
            state_d  = S_START;
          end
        end
      end
      S_START: begin
        if (op_q == ilf_pkg::OP_EVAL) begin
          acc_d     = '0;
          start_mul = 1'b1;
          start_idx = M_DET_A;
        end else begin
          acc_d     = ilf_pkg::wide_t'(sums.sxx);
          start_mul = 1'b1;
          start_idx = M_XX;
        end
      end
      S_MUL: begin
        acc_d    = alu_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q + ilf_pkg::STEP_W'(1);
        if (step_q == ilf_pkg::MUL_LAST) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        unique case (mi_q)
          M_XX: begin
            upd.wr_xx = 1'b1;
            acc_d     = ilf_pkg::wide_t'(sums.sxy);
            start_mul = 1'b1;
            start_idx = M_XY;
          end
          M_XY: begin
            upd.commit = 1'b1;
            status_d   = ilf_pkg::ST_ACCEPT;
            state_d    = S_DONE;
          end
          M_DET_A: begin
            start_mul = 1'b1;
            start_idx = M_DET_B;
          end
          M_DET_B: begin
            det_d   = acc_q;
            state_d = S_ABS;
          end
          M_ONUM_A: begin
            start_mul = 1'b1;
            start_idx = M_ONUM_B;
          end
          M_ONUM_B: begin
            num_d     = acc_q;
            acc_d     = '0;
            start_mul = 1'b1;
            start_idx = M_SNUM_A;
          end
          M_SNUM_A: begin
            start_mul = 1'b1;
            start_idx = M_SNUM_B;
          end
          M_SNUM_B: begin
            job_d   = J_OFF_FIT;
            state_d = S_DABS;
          end
        endcase
      end
      S_ABS: begin
        den_neg_d = det_q[ilf_pkg::WIDE_W-1];
        if (det_q[ilf_pkg::WIDE_W-1]) begin
          det_d = alu_sum;
        end
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!alu_carry) begin
          acc_d     = '0;
          start_mul = 1'b1;
          start_idx = M_ONUM_A;
        end else if (!sums.empty) begin
          num_d     = ilf_pkg::wide_t'(sums.sy);
          det_d     = ilf_pkg::wide_t'(sums.cnt);
          den_neg_d = 1'b0;
          job_d     = J_OFF_MEAN;
          state_d   = S_DABS;
        end else begin
          status_d  = ilf_pkg::ST_EMPTY;
          state_d   = S_DONE;
        end
      end
      S_DABS: begin
        r_d     = num_q[ilf_pkg::WIDE_W-1] ? alu_sum : num_q;
        dneg_d  = num_q[ilf_pkg::WIDE_W-1] ^ den_neg_q;
        state_d = S_DRND;
      end
      S_DRND: begin
        // 2|n| + |d| over 2|d|, first trial at 2|d| << 32
        r_d     = alu_sum;
        mcand_d = det_q << (ilf_pkg::Q_W + 1);
        state_d = S_DCHK;
      end
      S_DCHK: begin
        if (alu_carry) begin
          sat_d   = 1'b1;
          state_d = S_DEND;
        end else begin
          sat_d   = 1'b0;
          mcand_d = mcand_q >> 1;
          step_d  = '0;
          q_d     = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (alu_carry) begin
          r_d = alu_sum;
        end
        q_d     = {q_q[ilf_pkg::Q_W-2:0], alu_carry};
        mcand_d = mcand_q >> 1;
        step_d  = step_q + ilf_pkg::STEP_W'(1);
        if (step_q == ilf_pkg::DIV_LAST) begin
          state_d = S_DEND;
        end
      end
      S_DEND: begin
        unique case (job_q)
          J_OFF_FIT: begin
            offset_d = div_res;
            num_d    = acc_q << ilf_pkg::SNUM_SH;
            job_d    = J_SLOPE;
            state_d  = S_DABS;
          end
          J_SLOPE: begin
            slope_d  = div_res;
            status_d = ilf_pkg::ST_FULL_FIT;
            state_d  = S_DONE;
          end
          J_OFF_MEAN: begin
            offset_d = div_res;
            status_d = ilf_pkg::ST_OFFSET;
            state_d  = S_DONE;
          end
          default: begin
            state_d  = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, sums.cnt, offset_q, slope_q, status_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (start_mul) begin
      mi_d    = start_idx;
      step_d  = '0;
      state_d = S_MUL;
      unique case (start_idx)
        M_XX: begin
          mcand_d  = ilf_pkg::wide_t'(x_q);
          mplier_d = ilf_pkg::sum1_t'(x_q);
        end
        M_XY: begin
          mcand_d  = ilf_pkg::wide_t'(x_q);
          mplier_d = ilf_pkg::sum1_t'(y_q);
        end
        M_DET_A: begin
          mcand_d  = ilf_pkg::wide_t'(sums.sxx);
          mplier_d = ilf_pkg::mplr_t'(sums.cnt);
        end
        M_DET_B: begin
          mcand_d  = ilf_pkg::wide_t'(sums.sx);
          mplier_d = sums.sx;
        end
        M_ONUM_A: begin
          mcand_d  = ilf_pkg::wide_t'(sums.sxx);
          mplier_d = sums.sy;
        end
        M_ONUM_B: begin
          mcand_d  = ilf_pkg::wide_t'(sums.sxy);
          mplier_d = sums.sx;
        end
        M_SNUM_A: begin
          mcand_d  = ilf_pkg::wide_t'(sums.sxy);
          mplier_d = ilf_pkg::mplr_t'(sums.cnt);
        end
        M_SNUM_B: begin
          mcand_d  = ilf_pkg::wide_t'(sums.sx);
          mplier_d = sums.sy;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    x_q       <= x_d;
    y_q       <= y_d;
    mi_q      <= mi_d;
    step_q    <= step_d;
    acc_q     <= acc_d;
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
    det_q     <= det_d;
    num_q     <= num_d;
    r_q       <= r_d;
    q_q       <= q_d;
    sat_q     <= sat_d;
    dneg_q    <= dneg_d;
    den_neg_q <= den_neg_d;
    job_q     <= job_d;
    status_q  <= status_d;
    slope_q   <= slope_d;
    offset_q  <= offset_d;
    m_data_q  <= m_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: rtl/ilf_alu.sv
// Shared wide add/subtract with carry out for the multiply, abs, compare and divide steps.
`timescale 1ns / 1ps

module ilf_alu (
  input  ilf_pkg::wide_t a_i,
  input  ilf_pkg::wide_t b_i,
  input  logic           sub_i,
  output ilf_pkg::wide_t sum_o,
  output logic           carry_o
);

  logic [ilf_pkg::WIDE_W:0] ext;

  // on subtract, carry set means a >= b unsigned
  assign ext = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)}
             + (ilf_pkg::WIDE_W + 1)'(sub_i);

  assign sum_o   = ext[ilf_pkg::WIDE_W-1:0];
  assign carry_o = ext[ilf_pkg::WIDE_W];

endmodule

// File: rtl/ilf_sums.sv
// Running sums, sample count and degenerate limit register.
`timescale 1ns / 1ps

module ilf_sums #(
  parameter int MAX_SAMPLES = ilf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ilf_pkg::sum_upd_t   upd_i,
  input  ilf_pkg::sum2_t      wr_data_i,
  input  logic                cfg_we_i,
  input  ilf_pkg::lim_t       cfg_wdata_i,
  output ilf_pkg::sum_state_t st_o,
  output ilf_pkg::lim_t       lim_o
);

  localparam logic [31:0] MaxW = 32'(MAX_SAMPLES);

  ilf_pkg::cnt_t  cnt_q, cnt_d;
  ilf_pkg::sum1_t sx_q, sx_d, sy_q, sy_d;
  ilf_pkg::sum2_t sxx_q, sxx_d, sxy_q, sxy_d;
  ilf_pkg::lim_t  lim_q, lim_d;
  ilf_pkg::sum1_t x_ext, y_ext;

  assign x_ext = ilf_pkg::sum1_t'(upd_i.x);
  assign y_ext = ilf_pkg::sum1_t'(upd_i.y);

  always_comb begin
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sxx_d = sxx_q;
    sy_d  = sy_q;
    sxy_d = sxy_q;
    lim_d = cfg_we_i ? cfg_wdata_i : lim_q;
    if (upd_i.wr_xx) begin
      sxx_d = wr_data_i;
    end
    if (upd_i.commit) begin
      sxy_d = wr_data_i;
      if (upd_i.remove) begin
        cnt_d = cnt_q - ilf_pkg::cnt_t'(1);
        sx_d  = sx_q - x_ext;
        sy_d  = sy_q - y_ext;
      end else begin
        cnt_d = cnt_q + ilf_pkg::cnt_t'(1);
        sx_d  = sx_q + x_ext;
        sy_d  = sy_q + y_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sxx_q <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      lim_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sx_q  <= sx_d;
      sxx_q <= sxx_d;
      sy_q  <= sy_d;
      sxy_q <= sxy_d;
      lim_q <= lim_d;
    end
  end

  always_comb begin
    st_o.cnt   = cnt_q;
    st_o.sx    = sx_q;
    st_o.sxx   = sxx_q;
    st_o.sy    = sy_q;
    st_o.sxy   = sxy_q;
    st_o.full  = (32'(cnt_q) >= MaxW) || (&cnt_q);
    st_o.empty = (cnt_q == '0);
  end

  assign lim_o = lim_q;

endmodule
